>>> sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Field widths, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef logic signed [DATA_W-1:0] data_t;

	// What every cell of the chain does on a clock edge
	typedef enum logic [2:0] {
		CELL_HOLD,    // keep contents
		CELL_SHR,     // take the left neighbour's contents (push at front)
		CELL_SHL,     // take the right neighbour's contents (pop at front)
		CELL_APPEND,  // first free cell loads the pushed value
		CELL_TRIM     // last occupied cell empties
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    value;
	} cell_ctl_t;

endpackage

>>> sv/dq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_if: request and response channels of the double-ended queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	data_t             value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
	logic               valid;
	logic               ready;
	data_t              result_value;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] count;
	logic               is_empty;

	modport source (output valid, result_value, status, count, is_empty, input ready);
	modport sink   (input valid, result_value, status, count, is_empty, output ready);
endinterface

>>> sv/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue chain
// Holds one entry and its occupancy flag; shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  data_t     left_data,
	input  logic      left_occ,
	input  data_t     right_data,
	input  logic      right_occ,
	output data_t     data,
	output logic      occ,
	output data_t     tap
);

	data_t data_q;
	logic  occ_q;
	logic  is_last;

	// last occupied cell of the chain
	assign is_last = occ_q && !right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_SHR:    occ_q <= left_occ;
				CELL_SHL:    occ_q <= right_occ;
				CELL_APPEND: if (!occ_q && left_occ) occ_q <= 1'b1;
				CELL_TRIM:   if (is_last) occ_q <= 1'b0;
				default:     occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_SHR:    data_q <= left_data;
			CELL_SHL:    data_q <= right_data;
			CELL_APPEND: if (!occ_q && left_occ) data_q <= ctl.value;
			default:     data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign occ  = occ_q;
	assign tap  = is_last ? data_q : '0;

endmodule

>>> sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit values in a chain of cells
// Front sits in cell 0; pushes and pops at the front shift the whole chain.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields                                   Transfer
// req      in   cmd[2:0], value[31:0]                    valid & ready
// rsp      out  result_value[31:0], status[1:0],         valid & ready
//               count[4:0], is_empty
//
// One command per cycle while rsp.ready is high: each command updates the cell
// chain and its response lands in the output register on the same edge.
// Response valid rises in the cycle after the request transfer.
// Reset clears occupancy and the count; entry data is not reset.
// req.ready is low only while a response waits and rsp.ready is low.
// The back value is taken from the last occupied cell through an OR of all
// cell taps, so its depth grows with log2(CAPACITY).
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	data_t             cell_data [CAPACITY];
	logic              cell_occ  [CAPACITY];
	data_t             cell_tap  [CAPACITY];
	cell_ctl_t         ctl;
	cell_op_t          op;
	logic              accept;
	logic              full;
	logic              empty;
	data_t             back_val;
	data_t             res_val;
	logic [STAT_W-1:0] res_stat;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_nx;

	logic               rsp_valid_q;
	data_t              rsp_value_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic               rsp_empty_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign full      = cell_occ[CAPACITY-1];
	assign empty     = !cell_occ[0];

	always_comb begin
		back_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_val = back_val | cell_tap[i];
		end
	end

	always_comb begin
		op       = CELL_HOLD;
		res_val  = '0;
		res_stat = ST_OK;
		cnt_nx   = cnt_q;
		unique case (req.cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					res_stat = ST_FULL;
				end else begin
					op     = CELL_SHR;
					cnt_nx = cnt_q + CNT_W'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					res_stat = ST_FULL;
				end else begin
					op     = CELL_APPEND;
					cnt_nx = cnt_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					res_val  = EMPTY_VALUE;
					res_stat = ST_EMPTY;
				end else begin
					op      = CELL_SHL;
					res_val = cell_data[0];
					cnt_nx  = cnt_q - CNT_W'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					res_val  = EMPTY_VALUE;
					res_stat = ST_EMPTY;
				end else begin
					op      = CELL_TRIM;
					res_val = back_val;
					cnt_nx  = cnt_q - CNT_W'(1);
				end
			end
			CMD_PEEK_FRONT: begin
				if (empty) begin
					res_val  = EMPTY_VALUE;
					res_stat = ST_EMPTY;
				end else begin
					res_val = cell_data[0];
				end
			end
			CMD_PEEK_BACK: begin
				if (empty) begin
					res_val  = EMPTY_VALUE;
					res_stat = ST_EMPTY;
				end else begin
					res_val = back_val;
				end
			end
			default: ;
		endcase
	end

	// drop the operation unless a request transfer happens
	assign ctl.op    = accept ? op : CELL_HOLD;
	assign ctl.value = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t left_d;
		data_t right_d;
		logic  left_o;
		logic  right_o;

		if (i == 0) begin : g_first
			assign left_d = req.value;
			assign left_o = 1'b1;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
			assign left_o = cell_occ[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
			assign right_o = 1'b0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
			assign right_o = cell_occ[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_data  (left_d),
			.left_occ   (left_o),
			.right_data (right_d),
			.right_occ  (right_o),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.tap        (cell_tap[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q  <= res_val;
			rsp_status_q <= res_stat;
			rsp_count_q  <= COUNT_W'(cnt_nx);
			rsp_empty_q  <= (cnt_nx == '0);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.count        = rsp_count_q;
	assign rsp.is_empty     = rsp_empty_q;

endmodule

>>> sv/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker: port-level checks of the double-ended queue
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input data_t              rsp_result_value,
	input logic [STAT_W-1:0]  rsp_status,
	input logic [COUNT_W-1:0] rsp_count,
	input logic               rsp_is_empty
);

	// every request transfer yields a response on the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request transfer without response");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
			&& $stable(rsp_status) && $stable(rsp_count))
		else $error("stalled response changed");

	// an empty answer carries the empty value and a zero count
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |->
			rsp_result_value == EMPTY_VALUE && rsp_count == '0 && rsp_is_empty)
		else $error("empty status with inconsistent fields");

	// a refused push reports a full store
	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |->
			rsp_count == COUNT_W'(CAPACITY) && !rsp_is_empty && rsp_result_value == '0)
		else $error("full status with inconsistent fields");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |-> rsp_count == '0)
		else $error("empty flag with nonzero count");

endmodule

bind double_ended_queue dq_checker #(.CAPACITY(CAPACITY)) u_dq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_value (rsp.result_value),
	.rsp_status       (rsp.status),
	.rsp_count        (rsp.count),
	.rsp_is_empty     (rsp.is_empty)
);
